@@ rtl/asrc_pkg.sv @@
// ----------------------------------------------------------------------------
// asrc_pkg
// Shared widths, register indexes, reset values and the command and status
// bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package asrc_pkg;

  // field widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned NUM_W      = 24;
  localparam int unsigned DEN_W      = 16;
  localparam int unsigned OUT_RATE_W = 18;
  localparam int unsigned PROD_W     = DEN_W + OUT_RATE_W;
  localparam int unsigned ACC_W      = 35;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_RATE_NUM = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RATE_DEN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_RATE = CFG_IDX_W'(2);

  // register reset values
  localparam logic [NUM_W-1:0]      RATE_NUM_RST = NUM_W'(32040);
  localparam logic [DEN_W-1:0]      RATE_DEN_RST = DEN_W'(1);
  localparam logic [OUT_RATE_W-1:0] OUT_RATE_RST = OUT_RATE_W'(32000);

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the accepted input item
    logic init;    // seed accumulator and threshold
    logic step;    // run one loop pass, emit when gated in
    logic finish;  // fold the remainder back into the phase
  } asrc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic more;      // another loop pass is due
    logic gate;      // captured gate of the current item
    logic out_free;  // output register can take a pair this cycle
  } asrc_status_t;

endpackage

@@ rtl/asrc_in_if.sv @@
// ----------------------------------------------------------------------------
// asrc_in_if
// Input channel: one stereo pair and its gate per transfer.
// ----------------------------------------------------------------------------
interface asrc_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [asrc_pkg::SAMPLE_W-1:0] left_in;
  logic signed [asrc_pkg::SAMPLE_W-1:0] right_in;
  logic                          gate;

  modport source (output valid, output left_in, output right_in, output gate,
                  input ready);
  modport sink   (input valid, input left_in, input right_in, input gate,
                  output ready);
endinterface

@@ rtl/asrc_out_if.sv @@
// ----------------------------------------------------------------------------
// asrc_out_if
// Output channel: one repeated stereo pair with run flags per transfer.
// ----------------------------------------------------------------------------
interface asrc_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [asrc_pkg::SAMPLE_W-1:0] left_out;
  logic signed [asrc_pkg::SAMPLE_W-1:0] right_out;
  logic                          last;
  logic                          clipped;

  modport source (output valid, output left_out, output right_out, output last,
                  output clipped, input ready);
  modport sink   (input valid, input left_out, input right_out, input last,
                  input clipped, output ready);
endinterface

@@ rtl/audio_sample_repeat_converter.sv @@
// ----------------------------------------------------------------------------
// audio_sample_repeat_converter
// Zero-order-hold stereo rate converter: repeats or drops sample pairs.
// ----------------------------------------------------------------------------
// After an accepted pair, the block seeds the accumulator and threshold, runs P
// loop passes through the single accumulator adder, where P is the number of
// passes for it (0 to MAX_REPEAT), folds the remainder into the phase and
// returns to idle, where the next pair is accepted. A gated-in pass waits while
// the output register still holds an untaken pair. The threshold product of
// rate_den and out_rate is registered behind the rate registers; any write to a
// listed register clears the phase.
module audio_sample_repeat_converter #(
  parameter int unsigned MAX_REPEAT = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [asrc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [asrc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  asrc_in_if.sink                         in_i,
  asrc_out_if.source                      out_o
);
  import asrc_pkg::*;

  asrc_cmd_t    cmd;
  asrc_status_t status;

  // sequencing
  asrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic and storage
  asrc_datapath #(
    .MAX_REPEAT (MAX_REPEAT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .left_i      (in_i.left_in),
    .right_i     (in_i.right_in),
    .gate_i      (in_i.gate),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .left_o      (out_o.left_out),
    .right_o     (out_o.right_out),
    .last_o      (out_o.last),
    .clipped_o   (out_o.clipped),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

@@ rtl/asrc_ctrl.sv @@
// ----------------------------------------------------------------------------
// asrc_ctrl
// Controller: takes one item, seeds the datapath, then sequences loop passes
// until the run ends, holding a gated-in pass while the output register is full.
// ----------------------------------------------------------------------------
module asrc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  asrc_pkg::asrc_status_t status_i,
  output asrc_pkg::asrc_cmd_t    cmd_o
);
  import asrc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.init = 1'b1;
        state_d    = ST_RUN;
      end
      ST_RUN: begin
        if (status_i.more) begin
          // a gated-in pass needs room in the output register
          if (!status_i.gate || status_i.out_free) begin
            cmd_o.step = 1'b1;
          end
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/asrc_datapath.sv @@
// ----------------------------------------------------------------------------
// asrc_datapath
// Datapath: rate registers, threshold multiplier, phase accumulator, pass
// counter and the output register.
// ----------------------------------------------------------------------------
module asrc_datapath #(
  parameter int unsigned MAX_REPEAT = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration
  input  logic                                   cfg_we_i,
  input  logic [asrc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [asrc_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  // input item
  input  logic signed [asrc_pkg::SAMPLE_W-1:0]   left_i,
  input  logic signed [asrc_pkg::SAMPLE_W-1:0]   right_i,
  input  logic                                   gate_i,
  // output pair
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [asrc_pkg::SAMPLE_W-1:0]   left_o,
  output logic signed [asrc_pkg::SAMPLE_W-1:0]   right_o,
  output logic                                   last_o,
  output logic                                   clipped_o,
  // controller link
  input  asrc_pkg::asrc_cmd_t                    cmd_i,
  output asrc_pkg::asrc_status_t                 status_o
);
  import asrc_pkg::*;

  localparam int unsigned PASS_W = $clog2(MAX_REPEAT + 1);
  localparam logic [PASS_W-1:0] PASS_MAX  = PASS_W'(MAX_REPEAT);
  localparam logic [PASS_W-1:0] PASS_LAST = PASS_W'(MAX_REPEAT - 1);

  logic [NUM_W-1:0]          rate_num_q;
  logic [DEN_W-1:0]          rate_den_q;
  logic [OUT_RATE_W-1:0]     out_rate_q;
  logic [PROD_W-1:0]         prod_q;
  logic [ACC_W-1:0]          thresh_q;
  logic [ACC_W-1:0]          acc_q;
  logic [ACC_W-1:0]          phase_q;
  logic [PASS_W-1:0]         pass_q;
  logic signed [SAMPLE_W-1:0] left_q, right_q;
  logic                      gate_q;

  logic                      out_valid_q;
  logic signed [SAMPLE_W-1:0] out_left_q, out_right_q;
  logic                      out_last_q, out_clipped_q;

  logic [ACC_W-1:0]          acc_next;
  logic                      below;
  logic                      at_limit;
  logic                      next_below;
  logic                      next_limit;
  logic                      out_free;
  logic                      emit;
  logic                      cfg_hit;

  // one loop pass
  assign acc_next   = acc_q + ACC_W'(rate_num_q);
  assign below      = acc_q < thresh_q;
  assign at_limit   = pass_q == PASS_MAX;
  assign next_below = acc_next < thresh_q;
  assign next_limit = pass_q == PASS_LAST;
  assign out_free   = !out_valid_q || out_ready_i;
  assign emit       = cmd_i.step && gate_q;

  assign status_o.more     = below && !at_limit;
  assign status_o.gate     = gate_q;
  assign status_o.out_free = out_free;

  assign cfg_hit = cfg_we_i && (cfg_idx_i == REG_RATE_NUM || cfg_idx_i == REG_RATE_DEN ||
                                cfg_idx_i == REG_OUT_RATE);

  // rate registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_num_q <= RATE_NUM_RST;
      rate_den_q <= RATE_DEN_RST;
      out_rate_q <= OUT_RATE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RATE_NUM: rate_num_q <= cfg_data_i[NUM_W-1:0];
        REG_RATE_DEN: rate_den_q <= cfg_data_i[DEN_W-1:0];
        REG_OUT_RATE: out_rate_q <= cfg_data_i[OUT_RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // threshold product, registered in the cycle after the rate registers
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(rate_den_q) * PROD_W'(out_rate_q);
  end

  // phase carried between items, cleared by a write to any listed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (cfg_hit) begin
      phase_q <= '0;
    end else if (cmd_i.finish) begin
      phase_q <= below ? '0 : acc_q - thresh_q;
    end
  end

  // item capture, accumulator and pass counter
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      left_q  <= left_i;
      right_q <= right_i;
      gate_q  <= gate_i;
    end
    if (cmd_i.init) begin
      acc_q    <= phase_q + ACC_W'(rate_num_q);
      thresh_q <= ACC_W'(prod_q) + ACC_W'(rate_num_q);
      pass_q   <= '0;
    end else if (cmd_i.step) begin
      acc_q  <= acc_next;
      pass_q <= pass_q + PASS_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_left_q    <= left_q;
      out_right_q   <= right_q;
      // last when the next pass would not run
      out_last_q    <= !next_below || next_limit;
      out_clipped_q <= next_below && next_limit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_o      = out_left_q;
  assign right_o     = out_right_q;
  assign last_o      = out_last_q;
  assign clipped_o   = out_clipped_q;

endmodule

@@ rtl/asrc_checker.sv @@
// ----------------------------------------------------------------------------
// asrc_checker
// Port-level checks on the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module asrc_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_i,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic signed [asrc_pkg::SAMPLE_W-1:0] left_i,
  input logic signed [asrc_pkg::SAMPLE_W-1:0] right_i,
  input logic                                 last_i,
  input logic                                 clipped_i
);
  import asrc_pkg::*;

  // clipped is only ever set on the final pair of a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (!clipped_i || last_i))
    else $error("clipped set on a pair that is not last");

  // one item in flight: input closes right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input ready right after an input transfer");

  // a waiting pair is not dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("output pair withdrawn before transfer");

  // a waiting pair keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      ($stable(left_i) && $stable(right_i) && $stable(last_i) && $stable(clipped_i)))
    else $error("output payload changed while stalled");

endmodule

bind audio_sample_repeat_converter asrc_checker u_asrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .left_i      (out_o.left_out),
  .right_i     (out_o.right_out),
  .last_i      (out_o.last),
  .clipped_i   (out_o.clipped)
);

@@ dv/audio_sample_repeat_converter_checker.sv @@
// ----------------------------------------------------------------------------
// audio_sample_repeat_converter_checker
// Watches the configuration port and both channels of the rate converter.
// Keeps its own copy of the rate registers and the phase accumulator. For
// every input transfer it works out the repeated pairs that are due. Each
// output transfer is checked against the oldest pair still waiting.
// ----------------------------------------------------------------------------
module audio_sample_repeat_converter_checker #(
  parameter int unsigned MAX_REPEAT = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [asrc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [asrc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  asrc_in_if                              in_mon,
  asrc_out_if                             out_mon,
  output int unsigned                     err_count_o,
  output int unsigned                     pending_o
);
  import asrc_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       last;
    logic                       clipped;
  } held_pair_t;

  // shadow registers and phase
  logic [NUM_W-1:0]      rate_num_q;
  logic [DEN_W-1:0]      rate_den_q;
  logic [OUT_RATE_W-1:0] out_rate_q;
  logic [ACC_W-1:0]      phase_q;

  held_pair_t held_pair_q[$];

  // run the repeat loop for one input pair and queue what it lets out
  task automatic predict_repeats(input logic signed [SAMPLE_W-1:0] left,
                                 input logic signed [SAMPLE_W-1:0] right,
                                 input logic gate);
    logic [ACC_W-1:0] thresh;
    logic [ACC_W-1:0] acc;
    int unsigned      passes;
    int unsigned      emitted;
    logic             cut;
    held_pair_t       pair;
    thresh  = ACC_W'(rate_den_q) * ACC_W'(out_rate_q) + ACC_W'(rate_num_q);
    acc     = phase_q + ACC_W'(rate_num_q);
    passes  = 0;
    emitted = 0;
    cut     = 1'b0;
    while (acc < thresh) begin
      if (passes >= MAX_REPEAT) begin
        cut = 1'b1;
        break;
      end
      if (gate) begin
        pair = '{left: left, right: right, last: 1'b0, clipped: 1'b0};
        held_pair_q = {held_pair_q, pair};
        emitted++;
      end
      acc = acc + ACC_W'(rate_num_q);
      passes++;
    end
    // a cut run leaves the accumulator short, the phase then floors at zero
    phase_q = (acc >= thresh) ? acc - thresh : '0;
    if (emitted > 0) begin
      held_pair_q[held_pair_q.size()-1].last    = 1'b1;
      held_pair_q[held_pair_q.size()-1].clipped = cut;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    held_pair_t seen;
    held_pair_t want;
    if (!rst_ni) begin
      rate_num_q  = RATE_NUM_RST;
      rate_den_q  = RATE_DEN_RST;
      out_rate_q  = OUT_RATE_RST;
      phase_q     = '0;
      held_pair_q.delete();
      err_count_o = 0;
      pending_o   = 0;
    end else begin
      // output transfer against the oldest waiting pair
      if (out_mon.valid && out_mon.ready) begin
        seen = '{left: out_mon.left_out, right: out_mon.right_out,
                 last: out_mon.last, clipped: out_mon.clipped};
        if (held_pair_q.size() == 0) begin
          err_count_o++;
          if (err_count_o <= REPORT_LIMIT)
            $display("checker: pair with nothing due: left %0d right %0d last %0b clipped %0b",
                     seen.left, seen.right, seen.last, seen.clipped);
        end else begin
          want = held_pair_q.pop_front();
          if (seen.left !== want.left || seen.right !== want.right ||
              seen.last !== want.last || seen.clipped !== want.clipped) begin
            err_count_o++;
            if (err_count_o <= REPORT_LIMIT)
              $display("checker: pair mismatch: expected %0d %0d %0b %0b, got %0d %0d %0b %0b",
                       want.left, want.right, want.last, want.clipped,
                       seen.left, seen.right, seen.last, seen.clipped);
          end
        end
      end

      // register write, unlisted indexes are ignored
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RATE_NUM: begin
            rate_num_q = cfg_data_i[NUM_W-1:0];
            phase_q    = '0;
          end
          REG_RATE_DEN: begin
            rate_den_q = cfg_data_i[DEN_W-1:0];
            phase_q    = '0;
          end
          REG_OUT_RATE: begin
            out_rate_q = cfg_data_i[OUT_RATE_W-1:0];
            phase_q    = '0;
          end
          default: begin
          end
        endcase
      end

      // input transfer
      if (in_mon.valid && in_mon.ready)
        predict_repeats(in_mon.left_in, in_mon.right_in, in_mon.gate);

      pending_o = held_pair_q.size();
    end
  end

endmodule

@@ dv/audio_sample_repeat_converter_tb.sv @@
// ----------------------------------------------------------------------------
// audio_sample_repeat_converter_tb
// Drives the rate converter with directed and random stereo pairs over a
// series of rate settings. The sender works in bursts, the receiver stalls
// on its own pattern, and a checker beside the block predicts and compares
// every repeated pair.
// ----------------------------------------------------------------------------
module audio_sample_repeat_converter_tb;
  import asrc_pkg::*;

  localparam int unsigned MAX_REPEAT    = 64;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned DRAIN_CYCLES  = 80;
  localparam int unsigned CYCLE_LIMIT   = 800000;
  localparam int unsigned RANDOM_PHASES = 5;
  localparam int unsigned PHASE_ITEMS   = 20;
  localparam longint unsigned NUM_MAX   = (64'd1 << NUM_W) - 1;

  // index outside the register list
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

  typedef enum int unsigned {
    PROFILE_RANDOM,
    PROFILE_UNITY,
    PROFILE_UP,
    PROFILE_HEAVY,
    PROFILE_DOWN
  } rate_profile_e;

  typedef enum int unsigned {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE,
    SINK_COMB
  } sink_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int unsigned err_count;
  int unsigned pending;
  int unsigned cycle_count;
  int unsigned burst_left;
  logic        hold_off_req;

  asrc_in_if  in_ch ();
  asrc_out_if out_ch ();

  audio_sample_repeat_converter #(
    .MAX_REPEAT (MAX_REPEAT)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  audio_sample_repeat_converter_checker #(
    .MAX_REPEAT (MAX_REPEAT)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("audio_sample_repeat_converter_tb: errors");
    $finish;
  end

  // one register write, called at a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // offer one pair until its transfer, bursts with random gaps in between
  task automatic send_pair(input logic [SAMPLE_W-1:0] left,
                           input logic [SAMPLE_W-1:0] right,
                           input logic gate);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    in_ch.valid    <= 1'b1;
    in_ch.left_in  <= left;
    in_ch.right_in <= right;
    in_ch.gate     <= gate;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    burst_left--;
  endtask

  // stop sending until every due pair is out and the block has gone idle
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // receiver: stall pattern changes per stretch, one long hold-off on request
  initial begin : sink_side
    sink_mode_e  mode;
    int unsigned stretch;
    int unsigned tick;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode    = sink_mode_e'($urandom_range(0, 3));
      stretch = $urandom_range(20, 200);
      for (tick = 0; tick < stretch; tick++) begin
        @(negedge clk_i);
        if (hold_off_req) begin
          out_ch.ready <= 1'b0;
          repeat (LONG_HOLD) @(negedge clk_i);
          hold_off_req = 1'b0;
        end
        case (mode)
          SINK_OPEN:   out_ch.ready <= 1'b1;
          SINK_COIN:   out_ch.ready <= ($urandom_range(0, 1) == 1);
          SINK_SPARSE: out_ch.ready <= ($urandom_range(0, 4) == 0);
          default:     out_ch.ready <= ((tick % 7) < 4);
        endcase
      end
    end
  end

  // stimulus
  initial begin : stimulus
    rate_profile_e         profile;
    longint unsigned       prod;
    longint unsigned       num_pick;
    logic [NUM_W-1:0]      num_v;
    logic [DEN_W-1:0]      den_v;
    logic [OUT_RATE_W-1:0] orate_v;
    int unsigned           phase;
    int unsigned           item;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    in_ch.valid    = 1'b0;
    in_ch.left_in  = '0;
    in_ch.right_in = '0;
    in_ch.gate     = 1'b0;
    hold_off_req   = 1'b0;
    burst_left     = 0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(negedge clk_i);

    // reset rates, sample extremes and a gated-off pair
    send_pair(16'h8000, 16'h7fff, 1'b1);
    send_pair(16'h7fff, 16'h8000, 1'b1);
    send_pair(16'h0000, 16'h0000, 1'b1);
    send_pair(16'hffff, 16'hffff, 1'b0);
    send_pair(16'h5555, 16'haaaa, 1'b1);
    drain();

    // zero step never advances, every pair runs to the repeat limit
    write_reg(REG_RATE_NUM, '0);
    send_pair(16'h1234, 16'hedcb, 1'b1);
    send_pair(16'h4321, 16'hbcde, 1'b0);
    drain();

    // smallest nonzero rates
    write_reg(REG_RATE_NUM, CFG_DATA_W'(1));
    write_reg(REG_RATE_DEN, CFG_DATA_W'(1));
    write_reg(REG_OUT_RATE, CFG_DATA_W'(1));
    send_pair(16'h0001, 16'hfffe, 1'b1);
    send_pair(16'h8001, 16'h7ffe, 1'b1);
    send_pair(16'h00ff, 16'hff00, 1'b1);
    drain();

    // write to an unlisted index keeps the phase
    write_reg(REG_UNUSED, '1);
    send_pair(16'h0f0f, 16'hf0f0, 1'b1);
    send_pair(16'h3c3c, 16'hc3c3, 1'b1);
    drain();

    // largest rates, each pair is cut at the repeat limit
    write_reg(REG_RATE_NUM, CFG_DATA_W'(NUM_MAX));
    write_reg(REG_RATE_DEN, CFG_DATA_W'({DEN_W{1'b1}}));
    write_reg(REG_OUT_RATE, CFG_DATA_W'({OUT_RATE_W{1'b1}}));
    send_pair(16'h7fff, 16'h7fff, 1'b1);
    send_pair(16'h8000, 16'h8000, 1'b1);
    drain();

    // zero denominator, threshold equals the step and nothing comes out
    write_reg(REG_RATE_DEN, '0);
    send_pair(16'h2468, 16'h1357, 1'b1);
    send_pair(16'hdb97, 16'heca8, 1'b1);
    drain();

    // zero output rate
    write_reg(REG_RATE_DEN, CFG_DATA_W'(3));
    write_reg(REG_OUT_RATE, '0);
    send_pair(16'h6666, 16'h9999, 1'b1);
    send_pair(16'h9999, 16'h6666, 1'b1);
    drain();

    // random rate settings with random pairs
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      profile = (phase == 0) ? PROFILE_UP : rate_profile_e'($urandom_range(0, 4));
      den_v   = DEN_W'($urandom_range(1, 16));
      orate_v = OUT_RATE_W'($urandom_range(1, (1 << OUT_RATE_W) - 1));
      prod    = 64'(den_v) * 64'(orate_v);
      case (profile)
        PROFILE_RANDOM: begin
          num_pick = $urandom_range(0, NUM_MAX);
          den_v    = DEN_W'($urandom);
          orate_v  = OUT_RATE_W'($urandom);
        end
        PROFILE_UNITY: num_pick = prod;
        PROFILE_UP:    num_pick = prod / $urandom_range(2, 12);
        PROFILE_HEAVY: num_pick = prod / $urandom_range(40, 90);
        default:       num_pick = prod * $urandom_range(2, 5);
      endcase
      if (profile != PROFILE_RANDOM && num_pick == 0)
        num_pick = 1;
      if (num_pick > NUM_MAX)
        num_pick = NUM_MAX;
      num_v = NUM_W'(num_pick);

      write_reg(REG_RATE_NUM, CFG_DATA_W'(num_v));
      write_reg(REG_RATE_DEN, CFG_DATA_W'(den_v));
      write_reg(REG_OUT_RATE, CFG_DATA_W'(orate_v));

      // first phase: receiver holds off while pairs keep coming
      if (phase == 0)
        hold_off_req = 1'b1;

      for (item = 0; item < PHASE_ITEMS; item++)
        send_pair(SAMPLE_W'($urandom), SAMPLE_W'($urandom), ($urandom_range(0, 7) != 0));
      drain();
    end

    if (err_count == 0 && pending == 0)
      $display("audio_sample_repeat_converter_tb: clean");
    else
      $display("audio_sample_repeat_converter_tb: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/asrc_pkg.sv
rtl/asrc_in_if.sv
rtl/asrc_out_if.sv
rtl/asrc_ctrl.sv
rtl/asrc_datapath.sv
rtl/audio_sample_repeat_converter.sv
rtl/asrc_checker.sv
dv/audio_sample_repeat_converter_checker.sv
dv/audio_sample_repeat_converter_tb.sv
